// ----- src/iss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_pkg
// shared types and constants for the image sample statistics unit
// ----------------------------------------------------------------------------
package iss_pkg;

  localparam int SAMPLE_BITS      = 16;
  localparam int MAX_SAMPLES_LOG2 = 24;
  localparam int SUM_BITS         = SAMPLE_BITS + MAX_SAMPLES_LOG2;
  localparam int CNT_BITS         = MAX_SAMPLES_LOG2 + 1;

  // depth of the result queue between front and back, a power of two
  localparam int QUEUE_DEPTH    = 2;
  localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic signed [SUM_BITS-1:0]    SUM_MAX    = {1'b0, {(SUM_BITS-1){1'b1}}};
  localparam logic signed [SUM_BITS-1:0]    SUM_MIN    = {1'b1, {(SUM_BITS-1){1'b0}}};

  // sticky infinity flag bits
  localparam logic [1:0] INF_POS = 2'b01;
  localparam logic [1:0] INF_NEG = 2'b10;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          is_nan;
    logic                          is_inf;
    logic                          last_sample;
  } iss_in_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] min_sample;
    logic signed [SAMPLE_BITS-1:0] max_sample;
    logic signed [SUM_BITS-1:0]    sample_sum;
    logic [1:0]                    sum_infinite;
    logic signed [SAMPLE_BITS-1:0] mean_sample;
    logic signed [SAMPLE_BITS-1:0] mean_nonzero;
    logic [CNT_BITS-1:0]           valid_count;
    logic [CNT_BITS-1:0]           nan_count;
    logic [CNT_BITS-1:0]           inf_count;
  } iss_out_t;

  // running totals of one image, also the queue entry
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] run_min;
    logic signed [SAMPLE_BITS-1:0] run_max;
    logic signed [SUM_BITS-1:0]    run_sum;
    logic signed [SUM_BITS-1:0]    nz_sum;
    logic [CNT_BITS-1:0]           valid_cnt;
    logic [CNT_BITS-1:0]           nz_cnt;
    logic [CNT_BITS-1:0]           nan_cnt;
    logic [CNT_BITS-1:0]           inf_cnt;
    logic [1:0]                    inf_seen;
  } iss_stats_t;

  localparam iss_stats_t STATS_RESET = '{
    run_min:   SAMPLE_MAX,
    run_max:   SAMPLE_MIN,
    run_sum:   '0,
    nz_sum:    '0,
    valid_cnt: '0,
    nz_cnt:    '0,
    nan_cnt:   '0,
    inf_cnt:   '0,
    inf_seen:  '0
  };

  // handshake between queue and back end
  typedef struct packed {
    logic       pop;
  } iss_qreq_t;

  typedef struct packed {
    logic       not_empty;
    logic       not_full;
  } iss_qstat_t;

endpackage

// ----- src/iss_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_front
// accumulates one image's statistics, one item per cycle while queue has room
// ----------------------------------------------------------------------------
module iss_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                item_valid,
  output logic                item_ready,
  input  iss_pkg::iss_in_t    item,
  input  logic                queue_not_full,
  output logic                push,
  output iss_pkg::iss_stats_t push_data
);

  iss_pkg::iss_stats_t stats;
  iss_pkg::iss_stats_t stats_next;
  logic                accept;
  logic signed [iss_pkg::SAMPLE_BITS-1:0] v;

  function automatic logic [iss_pkg::CNT_BITS-1:0] count_up(
    input logic [iss_pkg::CNT_BITS-1:0] c
  );
    return (&c) ? c : c + 1'b1;
  endfunction

  function automatic logic signed [iss_pkg::SUM_BITS-1:0] sat_add(
    input logic signed [iss_pkg::SUM_BITS-1:0]    acc,
    input logic signed [iss_pkg::SAMPLE_BITS-1:0] s
  );
    logic signed [iss_pkg::SUM_BITS:0] wide;
    wide = {acc[iss_pkg::SUM_BITS-1], acc} + (iss_pkg::SUM_BITS+1)'(s);
    if (wide[iss_pkg::SUM_BITS] != wide[iss_pkg::SUM_BITS-1]) begin
      return wide[iss_pkg::SUM_BITS] ? iss_pkg::SUM_MIN : iss_pkg::SUM_MAX;
    end
    return wide[iss_pkg::SUM_BITS-1:0];
  endfunction

  // any item stalls while the queue is full, since a last item needs a free slot
  assign item_ready = queue_not_full;
  assign accept     = item_valid && item_ready;

  always_comb begin
    stats_next = stats;
    v          = item.sample;
    if (item.is_nan) begin
      stats_next.nan_cnt = count_up(stats.nan_cnt);
    end else begin
      stats_next.valid_cnt = count_up(stats.valid_cnt);
      if (item.is_inf) begin
        stats_next.inf_cnt = count_up(stats.inf_cnt);
        stats_next.nz_cnt  = count_up(stats.nz_cnt);
        // zero with the infinity flag counts as positive
        if (item.sample[iss_pkg::SAMPLE_BITS-1]) begin
          v                   = iss_pkg::SAMPLE_MIN;
          stats_next.inf_seen = stats.inf_seen | iss_pkg::INF_NEG;
        end else begin
          v                   = iss_pkg::SAMPLE_MAX;
          stats_next.inf_seen = stats.inf_seen | iss_pkg::INF_POS;
        end
      end else begin
        stats_next.run_sum = sat_add(stats.run_sum, item.sample);
        if (item.sample != '0) begin
          stats_next.nz_sum = sat_add(stats.nz_sum, item.sample);
          stats_next.nz_cnt = count_up(stats.nz_cnt);
        end
      end
      if (v < stats.run_min) stats_next.run_min = v;
      if (v > stats.run_max) stats_next.run_max = v;
    end
  end

  assign push      = accept && item.last_sample;
  assign push_data = stats_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      stats <= iss_pkg::STATS_RESET;
    end else if (accept) begin
      stats <= item.last_sample ? iss_pkg::STATS_RESET : stats_next;
    end
  end

endmodule

// ----- src/iss_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_queue
// short queue of finished image totals between front and back
// ----------------------------------------------------------------------------
module iss_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  iss_pkg::iss_stats_t push_data,
  input  iss_pkg::iss_qreq_t  req,
  output iss_pkg::iss_qstat_t stat,
  output iss_pkg::iss_stats_t head
);

  iss_pkg::iss_stats_t                  entries [iss_pkg::QUEUE_DEPTH];
  logic [iss_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr;
  logic [iss_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr;
  logic [iss_pkg::QUEUE_CNT_BITS-1:0]   fill;
  logic                                 do_pop;

  assign stat.not_empty = (fill != '0);
  assign stat.not_full  = (fill != iss_pkg::QUEUE_CNT_BITS'(iss_pkg::QUEUE_DEPTH));
  assign head           = entries[rd_ptr];
  assign do_pop         = req.pop && stat.not_empty;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // pointers wrap naturally, depth is a power of two
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push)   wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      case ({push, do_pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ----- src/iss_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_div
// radix-2 restoring divider, signed sum by unsigned count, clamped quotient
// ----------------------------------------------------------------------------
module iss_div (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic signed [iss_pkg::SUM_BITS-1:0]   dividend,
  input  logic [iss_pkg::CNT_BITS-1:0]          divisor,
  output logic                                  done,
  output logic signed [iss_pkg::SAMPLE_BITS-1:0] quotient
);

  localparam int STEP_BITS = $clog2(iss_pkg::SUM_BITS + 1);
  localparam logic [iss_pkg::SUM_BITS-1:0] POS_LIMIT =
    iss_pkg::SUM_BITS'(iss_pkg::SAMPLE_MAX);
  localparam logic [iss_pkg::SUM_BITS-1:0] NEG_LIMIT = POS_LIMIT + 1'b1;

  logic                             busy;
  logic [STEP_BITS-1:0]             step;
  logic                             neg;
  logic [iss_pkg::CNT_BITS-1:0]     dvs;
  logic [iss_pkg::CNT_BITS-1:0]     rem;
  logic [iss_pkg::SUM_BITS-1:0]     quo;
  logic [iss_pkg::CNT_BITS:0]       trial;
  logic [iss_pkg::CNT_BITS:0]       diff;
  logic                             fits;

  // one quotient bit per cycle
  assign trial = {rem, quo[iss_pkg::SUM_BITS-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= STEP_BITS'(iss_pkg::SUM_BITS);
      end else if (busy) begin
        step <= step - 1'b1;
        if (step == STEP_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[iss_pkg::SUM_BITS-1];
      dvs <= divisor;
      rem <= '0;
      quo <= dividend[iss_pkg::SUM_BITS-1] ? -dividend : dividend;
    end else if (busy) begin
      rem <= fits ? diff[iss_pkg::CNT_BITS-1:0] : trial[iss_pkg::CNT_BITS-1:0];
      quo <= {quo[iss_pkg::SUM_BITS-2:0], fits};
    end
  end

  // sign restore and clamp to the sample range
  always_comb begin
    if (neg) begin
      quotient = (quo > NEG_LIMIT) ? iss_pkg::SAMPLE_MIN
                                   : -quo[iss_pkg::SAMPLE_BITS-1:0];
    end else begin
      quotient = (quo > POS_LIMIT) ? iss_pkg::SAMPLE_MAX
                                   : quo[iss_pkg::SAMPLE_BITS-1:0];
    end
  end

endmodule

// ----- src/iss_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iss_back
// forms both means of one queued image and holds the result item
// ----------------------------------------------------------------------------
module iss_back (
  input  logic                clk,
  input  logic                rst,
  input  iss_pkg::iss_qstat_t qstat,
  input  iss_pkg::iss_stats_t head,
  output iss_pkg::iss_qreq_t  qreq,
  output logic                result_valid,
  input  logic                result_ready,
  output iss_pkg::iss_out_t   result
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_MEAN = 4'b0010,
    ST_NZ   = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t                                 state;
  state_t                                 state_next;
  iss_pkg::iss_stats_t                    entry;
  logic signed [iss_pkg::SAMPLE_BITS-1:0] mean_all;
  logic signed [iss_pkg::SAMPLE_BITS-1:0] mean_nz;
  logic                                   div_start;
  logic signed [iss_pkg::SUM_BITS-1:0]    div_dividend;
  logic [iss_pkg::CNT_BITS-1:0]           div_divisor;
  logic                                   div_done;
  logic signed [iss_pkg::SAMPLE_BITS-1:0] div_quotient;
  logic                                   out_free;
  logic                                   any_inf;

  iss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign out_free = !result_valid || result_ready;
  assign any_inf  = (entry.inf_seen != '0);

  always_comb begin
    state_next   = state;
    qreq.pop     = 1'b0;
    div_start    = 1'b0;
    div_dividend = head.run_sum;
    div_divisor  = head.valid_cnt;
    unique case (state)
      ST_IDLE: begin
        if (qstat.not_empty) begin
          qreq.pop   = 1'b1;
          div_start  = 1'b1;
          state_next = ST_MEAN;
        end
      end
      ST_MEAN: begin
        div_dividend = entry.nz_sum;
        div_divisor  = entry.nz_cnt;
        if (div_done) begin
          div_start  = 1'b1;
          state_next = ST_NZ;
        end
      end
      ST_NZ: begin
        if (div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && out_free) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && qstat.not_empty) begin
      entry <= head;
    end
    // empty count or infinity seen reads zero
    if (state == ST_MEAN && div_done) begin
      mean_all <= (entry.valid_cnt == '0 || any_inf) ? '0 : div_quotient;
    end
    if (state == ST_NZ && div_done) begin
      mean_nz <= (entry.nz_cnt == '0 || any_inf) ? '0 : div_quotient;
    end
    if (state == ST_OUT && out_free) begin
      result.min_sample   <= entry.run_min;
      result.max_sample   <= entry.run_max;
      result.sample_sum   <= entry.run_sum;
      result.sum_infinite <= entry.inf_seen;
      result.mean_sample  <= mean_all;
      result.mean_nonzero <= mean_nz;
      result.valid_count  <= entry.valid_cnt;
      result.nan_count    <= entry.nan_cnt;
      result.inf_count    <= entry.inf_cnt;
    end
  end

endmodule

// ----- src/image_sample_statistics_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// image_sample_statistics_unit
// streaming min, max, sum and mean statistics over the samples of one image
// ----------------------------------------------------------------------------
// Samples are taken at one item per clock cycle for as long as the result
// queue has room; the front end updates min, max, saturating sums and
// saturating counters in the cycle of acceptance and needs no recovery time.
// The item flagged last closes the image: its totals enter a two-entry queue
// and the running state returns to its reset values at once, so the next
// image may start in the following cycle. The back end takes one queued
// image at a time and forms both means with one shared restoring divider
// that yields one quotient bit per cycle; the result is loaded after both
// divisions once the output register is free, and the back end returns to
// idle for the next image as its result is loaded. Input stalls while both
// queue entries hold finished images, i.e. when images are shorter than the
// divider time; otherwise the sustained rate is one item per cycle. A mean
// over zero samples, or any mean once an infinity was seen, reads zero.
// ----------------------------------------------------------------------------
module image_sample_statistics_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  iss_pkg::iss_in_t  item,
  output logic              result_valid,
  input  logic              result_ready,
  output iss_pkg::iss_out_t result
);

  // totals of a finished image, front to queue
  logic                push;
  iss_pkg::iss_stats_t push_data;

  // queue to back end
  iss_pkg::iss_qreq_t  qreq;
  iss_pkg::iss_qstat_t qstat;
  iss_pkg::iss_stats_t head;

  // per-item accumulation, one item per cycle while the queue has room
  iss_front u_front (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_ready     (item_ready),
    .item           (item),
    .queue_not_full (qstat.not_full),
    .push           (push),
    .push_data      (push_data)
  );

  // decouples the per-item front from the slow per-image back end
  iss_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .req       (qreq),
    .stat      (qstat),
    .head      (head)
  );

  // means by iterative division and the result register
  iss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qstat        (qstat),
    .head         (head),
    .qreq         (qreq),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
